@@ design/csawr_pkg.sv @@
package csawr_pkg;

    // Default sizes of the stores. Ring and table sizes are powers of two, so
    // a slot index is the low bits of its sequence or probe position.
    localparam int RING_SLOTS_DEF  = 1024;
    localparam int HOLD_SLOTS_DEF  = 16;
    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int PROBE_RUN_DEF   = 8;
    localparam int SEQ_WIDTH_DEF   = 48;

    // Request codes.
    localparam logic [3:0] OP_NEXT      = 4'd0;
    localparam logic [3:0] OP_CURRENT   = 4'd1;
    localparam logic [3:0] OP_MARK      = 4'd2;
    localparam logic [3:0] OP_COMMITTED = 4'd3;
    localparam logic [3:0] OP_VISIBLE   = 4'd4;
    localparam logic [3:0] OP_HOLD      = 4'd5;
    localparam logic [3:0] OP_UNHOLD    = 4'd6;
    localparam logic [3:0] OP_RESEED    = 4'd7;
    localparam logic [3:0] OP_RESERVE   = 4'd8;
    localparam logic [3:0] OP_CHECKED   = 4'd9;
    localparam logic [3:0] OP_REASSIGN  = 4'd10;
    localparam logic [3:0] OP_RELEASE   = 4'd11;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_REFRESH  = 3'd2;
    localparam logic [2:0] ST_CHECK    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_SLOT_GO, S_SLOT_WAIT, S_CLAIM_RD, S_CLAIM,
        S_RING_GO, S_RING_WAIT, S_BIT_RD, S_EVAL, S_NEXT, S_FINISH, S_FILL, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DC_NONE, DC_CLEAR, DC_ACCEPT, DC_SIMPLE, DC_QINIT, DC_RESEED, DC_RUNINIT,
        DC_CLAIMRD, DC_CLAIM, DC_BITRD, DC_MARK, DC_EVAL, DC_QANS, DC_NEXTP,
        DC_FINISH, DC_FILL
    } t_dp_cmd;

    typedef enum logic {
        MS_SLOT, MS_RING
    } t_mod_sel;

    typedef struct packed {
        t_dp_cmd  code;
        logic     mod_start;
        t_mod_sel mod_sel;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       sa_zero;
        logic       pre_ok;
        logic       cur_match;
        logic       cur_free;
        logic       eval_stop;
        logic       last_probe;
        logic       fill_last;
        logic       clr_last;
        logic       mod_done;
    } t_stat;

endpackage

@@ design/csawr_mod.sv @@
// Slot index unit: the remainder by a power-of-two count is the masked low bits.
// The index is registered and ready the cycle after start.
module csawr_mod #(
    parameter int SW = csawr_pkg::SEQ_WIDTH_DEF,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [DW-1:0] o_rem,
    output logic          o_done
);

    logic [DW-1:0] r_rem;
    logic          r_done;

    // Keep the low bits below the count and flag them in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) r_rem <= i_dividend[DW-1:0] & (i_divisor - 1'b1);
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

@@ design/csawr_ctrl.sv @@
// Sequencer for all requests.
module csawr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  csawr_pkg::t_stat i_stat,
    output csawr_pkg::t_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_valid
);

    csawr_pkg::t_state r_state, n_state;
    logic              w_run_op;

    assign w_run_op = (i_stat.op == csawr_pkg::OP_RESERVE)
                   || (i_stat.op == csawr_pkg::OP_CHECKED)
                   || (i_stat.op == csawr_pkg::OP_REASSIGN)
                   || (i_stat.op == csawr_pkg::OP_RELEASE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            csawr_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = csawr_pkg::S_IDLE;
            end
            csawr_pkg::S_IDLE: begin
                if (i_start) n_state = csawr_pkg::S_DISP;
            end
            csawr_pkg::S_DISP: begin
                if (w_run_op) begin
                    n_state = i_stat.pre_ok ? csawr_pkg::S_SLOT_GO : csawr_pkg::S_DONE;
                end else if (i_stat.op == csawr_pkg::OP_MARK
                          || i_stat.op == csawr_pkg::OP_RESEED) begin
                    n_state = i_stat.sa_zero ? csawr_pkg::S_DONE : csawr_pkg::S_RING_GO;
                end else if (i_stat.op == csawr_pkg::OP_COMMITTED
                          || i_stat.op == csawr_pkg::OP_VISIBLE) begin
                    n_state = csawr_pkg::S_RING_GO;
                end else begin
                    n_state = csawr_pkg::S_DONE;
                end
            end
            csawr_pkg::S_SLOT_GO:   n_state = csawr_pkg::S_SLOT_WAIT;
            csawr_pkg::S_SLOT_WAIT: begin
                if (i_stat.mod_done) n_state = csawr_pkg::S_CLAIM_RD;
            end
            csawr_pkg::S_CLAIM_RD:  n_state = csawr_pkg::S_CLAIM;
            csawr_pkg::S_CLAIM: begin
                if (i_stat.cur_match) begin
                    n_state = csawr_pkg::S_DONE;
                end else if (i_stat.op == csawr_pkg::OP_RESERVE && !i_stat.cur_free) begin
                    n_state = csawr_pkg::S_RING_GO;
                end else begin
                    n_state = csawr_pkg::S_NEXT;
                end
            end
            csawr_pkg::S_RING_GO:   n_state = csawr_pkg::S_RING_WAIT;
            csawr_pkg::S_RING_WAIT: begin
                if (i_stat.mod_done) begin
                    n_state = (i_stat.op == csawr_pkg::OP_RESEED) ? csawr_pkg::S_FILL
                                                                  : csawr_pkg::S_BIT_RD;
                end
            end
            csawr_pkg::S_BIT_RD: begin
                n_state = (i_stat.op == csawr_pkg::OP_MARK) ? csawr_pkg::S_DONE
                                                            : csawr_pkg::S_EVAL;
            end
            csawr_pkg::S_EVAL: begin
                if (i_stat.op == csawr_pkg::OP_RESERVE && !i_stat.eval_stop) begin
                    n_state = csawr_pkg::S_NEXT;
                end else begin
                    n_state = csawr_pkg::S_DONE;
                end
            end
            csawr_pkg::S_NEXT: begin
                if (!i_stat.last_probe) begin
                    n_state = csawr_pkg::S_SLOT_GO;
                end else if (i_stat.op == csawr_pkg::OP_RESERVE) begin
                    n_state = csawr_pkg::S_FINISH;
                end else begin
                    n_state = csawr_pkg::S_DONE;
                end
            end
            csawr_pkg::S_FINISH: n_state = csawr_pkg::S_DONE;
            csawr_pkg::S_FILL: begin
                if (i_stat.fill_last) n_state = csawr_pkg::S_DONE;
            end
            csawr_pkg::S_DONE: n_state = csawr_pkg::S_IDLE;
            default: n_state = csawr_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.code      = csawr_pkg::DC_NONE;
        o_cmd.mod_start = 1'b0;
        o_cmd.mod_sel   = csawr_pkg::MS_SLOT;
        case (r_state)
            csawr_pkg::S_CLEAR: o_cmd.code = csawr_pkg::DC_CLEAR;
            csawr_pkg::S_IDLE: begin
                if (i_start) o_cmd.code = csawr_pkg::DC_ACCEPT;
            end
            csawr_pkg::S_DISP: begin
                if (w_run_op) begin
                    if (i_stat.pre_ok) o_cmd.code = csawr_pkg::DC_RUNINIT;
                end else if (i_stat.op == csawr_pkg::OP_MARK
                          || i_stat.op == csawr_pkg::OP_COMMITTED
                          || i_stat.op == csawr_pkg::OP_VISIBLE) begin
                    o_cmd.code = csawr_pkg::DC_QINIT;
                end else if (i_stat.op == csawr_pkg::OP_RESEED) begin
                    if (!i_stat.sa_zero) o_cmd.code = csawr_pkg::DC_RESEED;
                end else begin
                    o_cmd.code = csawr_pkg::DC_SIMPLE;
                end
            end
            csawr_pkg::S_SLOT_GO: o_cmd.mod_start = 1'b1;
            csawr_pkg::S_CLAIM_RD: o_cmd.code = csawr_pkg::DC_CLAIMRD;
            csawr_pkg::S_CLAIM: o_cmd.code = csawr_pkg::DC_CLAIM;
            csawr_pkg::S_RING_GO: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel   = csawr_pkg::MS_RING;
            end
            csawr_pkg::S_BIT_RD: begin
                o_cmd.code = (i_stat.op == csawr_pkg::OP_MARK) ? csawr_pkg::DC_MARK
                                                               : csawr_pkg::DC_BITRD;
            end
            csawr_pkg::S_EVAL: begin
                o_cmd.code = (i_stat.op == csawr_pkg::OP_RESERVE) ? csawr_pkg::DC_EVAL
                                                                  : csawr_pkg::DC_QANS;
            end
            csawr_pkg::S_NEXT: begin
                if (!i_stat.last_probe) o_cmd.code = csawr_pkg::DC_NEXTP;
            end
            csawr_pkg::S_FINISH: o_cmd.code = csawr_pkg::DC_FINISH;
            csawr_pkg::S_FILL: o_cmd.code = csawr_pkg::DC_FILL;
            default: o_cmd.code = csawr_pkg::DC_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csawr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != csawr_pkg::S_IDLE);
    assign o_valid = (r_state == csawr_pkg::S_DONE);

    // A result is followed by an idle cycle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == csawr_pkg::S_DONE |=> r_state == csawr_pkg::S_IDLE)
        else $error("result not followed by idle");

    // An accepted beat goes to dispatch.
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csawr_pkg::S_IDLE && i_start) |=> r_state == csawr_pkg::S_DISP)
        else $error("accepted beat not dispatched");

    // A finished slot remainder leads to the claim read.
    a_slot_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csawr_pkg::S_SLOT_WAIT && i_stat.mod_done)
        |=> r_state == csawr_pkg::S_CLAIM_RD)
        else $error("slot remainder not followed by claim read");

endmodule

@@ design/csawr_dpath.sv @@
// Sequence counter, commit ring, hold list, claim table and result registers.
module csawr_dpath #(
    parameter int RING_SLOTS  = csawr_pkg::RING_SLOTS_DEF,
    parameter int HOLD_SLOTS  = csawr_pkg::HOLD_SLOTS_DEF,
    parameter int TABLE_SLOTS = csawr_pkg::TABLE_SLOTS_DEF,
    parameter int PROBE_RUN   = csawr_pkg::PROBE_RUN_DEF,
    parameter int SEQ_WIDTH   = csawr_pkg::SEQ_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  csawr_pkg::t_cmd  i_cmd,
    output csawr_pkg::t_stat o_stat,
    input  logic [3:0]       i_op,
    input  logic [63:0]      i_key_hash,
    input  logic [47:0]      i_seq_a,
    input  logic [47:0]      i_seq_b,
    input  logic [47:0]      i_floor_seq,
    input  logic             i_commit_flag,
    input  logic [63:0]      i_packed_in,
    output logic [2:0]       o_status,
    output logic [63:0]      o_value_out,
    output logic             o_flag
);

    localparam int SW  = SEQ_WIDTH;
    localparam int RW  = $clog2(RING_SLOTS);
    localparam int TW  = $clog2(TABLE_SLOTS);
    localparam int CL  = (TABLE_SLOTS > RING_SLOTS) ? TABLE_SLOTS : RING_SLOTS;
    localparam int CW  = $clog2(CL);
    localparam int DW  = $clog2(CL + 1);
    localparam int PW  = $clog2(PROBE_RUN + 1);
    localparam logic [SW-1:0] SEQ_MAX = '1;
    localparam logic [SW-1:0] RING_SEQ = SW'(RING_SLOTS);

    // Latched request.
    logic [3:0]    r_op;
    logic [63:0]   r_key;
    logic [SW-1:0] r_sa, r_sb, r_floor;
    logic          r_cflag;
    logic [63:0]   r_packed;

    // Result.
    logic [2:0]  r_status, n_status;
    logic [63:0] r_value, n_value;
    logic        r_flag, n_flag;

    // Store state.
    logic [SW-1:0] r_next, n_next;
    logic [SW-1:0] r_hw, n_hw;
    logic [SW-1:0] r_held [HOLD_SLOTS];
    logic [SW-1:0] n_held [HOLD_SLOTS];
    logic [CW-1:0] r_clr, n_clr;

    // Probe run state.
    logic [PW-1:0] r_p, n_p;
    logic [TW-1:0] r_slot, n_slot;
    logic [63:0]   r_cur;
    logic [SW-1:0] r_cs, n_cs;
    logic          r_bit;
    logic          r_claim_vld, n_claim_vld;
    logic [TW-1:0] r_claim_slot, n_claim_slot;
    logic [63:0]   r_check, n_check;
    logic          r_same_above, n_same_above;
    logic          r_stranger_above, n_stranger_above;
    logic [RW-1:0] r_fill_addr, n_fill_addr;
    logic [RW:0]   r_fill_cnt, n_fill_cnt;

    // Memories.
    logic [63:0] claim_mem [TABLE_SLOTS];
    logic        commit_mem [RING_SLOTS];

    logic          cl_we;
    logic [TW-1:0] cl_wa;
    logic [63:0]   cl_wd;
    logic          cm_we;
    logic [RW-1:0] cm_wa;
    logic          cm_wd;

    // Remainder unit.
    logic [SW-1:0] w_dividend;
    logic [DW-1:0] w_divisor;
    logic [DW-1:0] w_rem;
    logic          w_mod_done;

    // Decoded values.
    logic [63-SW:0] w_fp;
    logic [63:0]    w_mine, w_expect, w_want;
    logic [SW-1:0]  w_cur_cs;
    logic           w_cur_same;
    logic           w_held_hit;
    logic           w_old;
    logic           w_committed;
    logic           w_pre_ok;

    assign w_fp     = r_key[63:SW];
    assign w_mine   = {w_fp, r_sa};
    assign w_cur_cs = r_cur[SW-1:0];
    assign w_cur_same = (r_cur[63:SW] == w_fp);

    // Expected and replacement words of the swap requests.
    always_comb begin
        w_expect = {w_fp, r_sa};
        w_want   = '0;
        w_pre_ok = 1'b1;
        case (r_op)
            csawr_pkg::OP_CHECKED: begin
                w_expect = r_packed;
                w_want   = {r_packed[63:SW], r_sa};
                w_pre_ok = (r_packed[SW-1:0] != '0) && (r_packed[63:SW] == w_fp);
            end
            csawr_pkg::OP_REASSIGN: begin
                w_want   = {w_fp, r_sb};
                w_pre_ok = (r_sa != '0) && (r_sb != '0);
            end
            csawr_pkg::OP_RELEASE: begin
                w_pre_ok = (r_sa != '0);
            end
            default: begin
                w_expect = {w_fp, r_sa};
            end
        endcase
    end

    // Hold list lookup of the sequence under test.
    always_comb begin
        w_held_hit = 1'b0;
        for (int i = 0; i < HOLD_SLOTS; i++) begin
            if (r_held[i] == r_cs) w_held_hit = 1'b1;
        end
    end

    // Commit state of the sequence under test.
    assign w_old = (r_hw >= RING_SEQ) && (r_cs <= r_hw - RING_SEQ);
    assign w_committed = (r_cs != '0) && (w_old ? !w_held_hit : r_bit);

    // Remainder source selection.
    assign w_dividend = (i_cmd.mod_sel == csawr_pkg::MS_RING) ? r_cs
                      : SW'(r_key[31:0] + 32'(r_p));
    assign w_divisor  = (i_cmd.mod_sel == csawr_pkg::MS_RING) ? DW'(RING_SLOTS)
                      : DW'(TABLE_SLOTS);

    csawr_mod #(
        .SW (SW),
        .DW (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_rem      (w_rem),
        .o_done     (w_mod_done)
    );

    // Register updates per command.
    always_comb begin
        logic v_found;
        v_found          = 1'b0;
        n_status         = r_status;
        n_value          = r_value;
        n_flag           = r_flag;
        n_next           = r_next;
        n_hw             = r_hw;
        n_held           = r_held;
        n_clr            = r_clr;
        n_p              = r_p;
        n_slot           = r_slot;
        n_cs             = r_cs;
        n_claim_vld      = r_claim_vld;
        n_claim_slot     = r_claim_slot;
        n_check          = r_check;
        n_same_above     = r_same_above;
        n_stranger_above = r_stranger_above;
        n_fill_addr      = w_mod_done ? w_rem[RW-1:0] : r_fill_addr;
        n_fill_cnt       = r_fill_cnt;
        case (i_cmd.code)
            csawr_pkg::DC_CLEAR: n_clr = r_clr + 1'b1;
            csawr_pkg::DC_ACCEPT: begin
                n_status = csawr_pkg::ST_OK;
                n_value  = '0;
                n_flag   = 1'b0;
            end
            csawr_pkg::DC_SIMPLE: begin
                case (r_op)
                    csawr_pkg::OP_NEXT: begin
                        n_value = 64'(r_next);
                        if (r_next < SEQ_MAX) n_next = r_next + 1'b1;
                    end
                    csawr_pkg::OP_CURRENT: n_value = 64'(r_next);
                    csawr_pkg::OP_HOLD: begin
                        if (r_sa == '0) begin
                            n_status = csawr_pkg::ST_INVALID;
                        end else begin
                            n_status = csawr_pkg::ST_CONFLICT;
                            for (int i = 0; i < HOLD_SLOTS; i++) begin
                                if (!v_found && r_held[i] == '0) begin
                                    n_held[i] = r_sa;
                                    v_found   = 1'b1;
                                    n_status  = csawr_pkg::ST_OK;
                                end
                            end
                        end
                    end
                    csawr_pkg::OP_UNHOLD: begin
                        if (r_sa != '0) begin
                            for (int i = 0; i < HOLD_SLOTS; i++) begin
                                if (!v_found && r_held[i] == r_sa) begin
                                    n_held[i] = '0;
                                    v_found   = 1'b1;
                                end
                            end
                        end
                    end
                    default: n_status = csawr_pkg::ST_INVALID;
                endcase
            end
            csawr_pkg::DC_QINIT: n_cs = r_sa;
            csawr_pkg::DC_RESEED: begin
                n_next = (r_sa < SEQ_MAX) ? r_sa + 1'b1 : SEQ_MAX;
                if (r_sa > r_hw) n_hw = r_sa;
                if (r_sa > RING_SEQ) begin
                    n_cs       = r_sa - RING_SEQ + 1'b1;
                    n_fill_cnt = (RW + 1)'(RING_SLOTS);
                end else begin
                    n_cs       = SW'(1);
                    n_fill_cnt = (RW + 1)'(r_sa);
                end
            end
            csawr_pkg::DC_RUNINIT: begin
                n_p              = '0;
                n_claim_vld      = 1'b0;
                n_check          = '0;
                n_same_above     = 1'b0;
                n_stranger_above = 1'b0;
            end
            csawr_pkg::DC_CLAIMRD: n_slot = w_rem[TW-1:0];
            csawr_pkg::DC_CLAIM: begin
                if (r_op == csawr_pkg::OP_RESERVE) begin
                    if (r_cur != w_mine) begin
                        if (w_cur_cs == '0) begin
                            if (!r_claim_vld) begin
                                n_claim_vld  = 1'b1;
                                n_claim_slot = r_slot;
                            end
                        end else begin
                            n_cs = w_cur_cs;
                        end
                    end
                end else if (r_cur == w_expect) begin
                    n_flag = (r_op == csawr_pkg::OP_CHECKED);
                end
            end
            csawr_pkg::DC_MARK: begin
                if (r_sa > r_hw) n_hw = r_sa;
            end
            csawr_pkg::DC_QANS: begin
                n_flag = w_committed && ((r_op == csawr_pkg::OP_COMMITTED) || (r_sa <= r_sb));
            end
            csawr_pkg::DC_EVAL: begin
                if (!w_committed) begin
                    if (w_cur_same) n_status = csawr_pkg::ST_CONFLICT;
                end else if (r_cs > r_sb && (w_cur_same || r_cs > r_floor)) begin
                    if (r_cs > r_floor) begin
                        if (w_cur_same) n_same_above = 1'b1;
                        else            n_stranger_above = 1'b1;
                    end else if (r_cs > r_check[SW-1:0]) begin
                        n_check = r_cur;
                    end
                end else if (!r_claim_vld) begin
                    n_claim_vld  = 1'b1;
                    n_claim_slot = r_slot;
                end
            end
            csawr_pkg::DC_NEXTP: n_p = r_p + 1'b1;
            csawr_pkg::DC_FINISH: begin
                if (r_same_above) begin
                    n_status = csawr_pkg::ST_REFRESH;
                end else if (r_check != '0) begin
                    n_status = csawr_pkg::ST_CHECK;
                    n_value  = r_check;
                end else if (!r_claim_vld) begin
                    n_status = r_stranger_above ? csawr_pkg::ST_REFRESH
                                                : csawr_pkg::ST_CONFLICT;
                end
            end
            csawr_pkg::DC_FILL: begin
                n_fill_addr = (r_fill_addr == RW'(RING_SLOTS - 1)) ? '0 : r_fill_addr + 1'b1;
                n_fill_cnt  = r_fill_cnt - 1'b1;
            end
            default: n_status = r_status;
        endcase
    end

    // Claim table write port.
    always_comb begin
        cl_we = 1'b0;
        cl_wa = r_slot;
        cl_wd = w_want;
        case (i_cmd.code)
            csawr_pkg::DC_CLEAR: begin
                cl_we = 1'b1;
                cl_wa = r_clr[TW-1:0];
                cl_wd = '0;
            end
            csawr_pkg::DC_CLAIM: begin
                cl_we = (r_op != csawr_pkg::OP_RESERVE) && (r_cur == w_expect);
            end
            csawr_pkg::DC_FINISH: begin
                cl_we = !r_same_above && (r_check == '0) && r_claim_vld;
                cl_wa = r_claim_slot;
                cl_wd = w_mine;
            end
            default: cl_we = 1'b0;
        endcase
    end

    // Commit ring write port.
    always_comb begin
        cm_we = 1'b0;
        cm_wa = r_fill_addr;
        cm_wd = 1'b1;
        case (i_cmd.code)
            csawr_pkg::DC_CLEAR: begin
                cm_we = (32'(r_clr) < RING_SLOTS);
                cm_wa = r_clr[RW-1:0];
                cm_wd = 1'b0;
            end
            csawr_pkg::DC_MARK: begin
                cm_we = 1'b1;
                cm_wa = w_rem[RW-1:0];
                cm_wd = r_cflag;
            end
            csawr_pkg::DC_FILL: cm_we = 1'b1;
            default: cm_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) claim_mem[cl_wa] <= cl_wd;
        if (i_cmd.code == csawr_pkg::DC_CLAIMRD) r_cur <= claim_mem[w_rem[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) commit_mem[cm_wa] <= cm_wd;
        if (i_cmd.code == csawr_pkg::DC_BITRD) r_bit <= commit_mem[w_rem[RW-1:0]];
    end

    // Store and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= SW'(1);
            r_hw   <= '0;
            r_clr  <= '0;
            for (int i = 0; i < HOLD_SLOTS; i++) r_held[i] <= '0;
        end else begin
            r_next <= n_next;
            r_hw   <= n_hw;
            r_clr  <= n_clr;
            r_held <= n_held;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == csawr_pkg::DC_ACCEPT) begin
            r_op     <= i_op;
            r_key    <= i_key_hash;
            r_sa     <= SW'(i_seq_a);
            r_sb     <= SW'(i_seq_b);
            r_floor  <= SW'(i_floor_seq);
            r_cflag  <= i_commit_flag;
            r_packed <= i_packed_in;
        end
        r_status         <= n_status;
        r_value          <= n_value;
        r_flag           <= n_flag;
        r_p              <= n_p;
        r_slot           <= n_slot;
        r_cs             <= n_cs;
        r_claim_vld      <= n_claim_vld;
        r_claim_slot     <= n_claim_slot;
        r_check          <= n_check;
        r_same_above     <= n_same_above;
        r_stranger_above <= n_stranger_above;
        r_fill_addr      <= n_fill_addr;
        r_fill_cnt       <= n_fill_cnt;
    end

    // Status back to the controller.
    assign o_stat.op         = r_op;
    assign o_stat.sa_zero    = (r_sa == '0);
    assign o_stat.pre_ok     = w_pre_ok;
    assign o_stat.cur_match  = (r_op == csawr_pkg::OP_RESERVE) ? (r_cur == w_mine)
                                                               : (r_cur == w_expect);
    assign o_stat.cur_free   = (w_cur_cs == '0);
    assign o_stat.eval_stop  = !w_committed && w_cur_same;
    assign o_stat.last_probe = (r_p == PW'(PROBE_RUN - 1));
    assign o_stat.fill_last  = (r_fill_cnt == (RW + 1)'(1));
    assign o_stat.clr_last   = (r_clr == CW'(CL - 1));
    assign o_stat.mod_done   = w_mod_done;

    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_flag      = r_flag;

    // A reserve that writes a claim has seen a free or stale slot.
    a_finish_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == csawr_pkg::DC_FINISH && cl_we) |-> r_claim_vld)
        else $error("claim written without a chosen slot");

    // The fill never runs with an empty count.
    a_fill_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.code == csawr_pkg::DC_FILL |-> r_fill_cnt != '0)
        else $error("ring fill with empty count");

    // A check-key status carries the observed word.
    a_check_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == csawr_pkg::DC_FINISH && !r_same_above && r_check != '0)
        |=> (r_status == csawr_pkg::ST_CHECK && r_value != '0))
        else $error("check key without occupant");

endmodule

@@ design/commit_status_and_write_reservation_top.sv @@
// Channel    Direction  Handshake              Beat
// request    in         i_start, o_busy        i_op, i_key_hash, i_seq_a, i_seq_b,
//                                              i_floor_seq, i_commit_flag, i_packed_in
// result     out        o_valid (one cycle)    o_status, o_value_out, o_flag
//
// One request at a time; a beat is taken when i_start is high and o_busy is low.
// A reseed sets one ring bit per cycle, and the probe requests (reserve, checked,
// reassign and release) take their probes one after another. After reset a clearing
// pass zeroes both memories with o_busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module commit_status_and_write_reservation_top #(
    parameter int RING_SLOTS  = csawr_pkg::RING_SLOTS_DEF,
    parameter int HOLD_SLOTS  = csawr_pkg::HOLD_SLOTS_DEF,
    parameter int TABLE_SLOTS = csawr_pkg::TABLE_SLOTS_DEF,
    parameter int PROBE_RUN   = csawr_pkg::PROBE_RUN_DEF,
    parameter int SEQ_WIDTH   = csawr_pkg::SEQ_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_op,
    input  logic [63:0] i_key_hash,
    input  logic [47:0] i_seq_a,
    input  logic [47:0] i_seq_b,
    input  logic [47:0] i_floor_seq,
    input  logic        i_commit_flag,
    input  logic [63:0] i_packed_in,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_value_out,
    output logic        o_flag
);

    csawr_pkg::t_cmd  w_cmd;
    csawr_pkg::t_stat w_stat;

    csawr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    csawr_dpath #(
        .RING_SLOTS  (RING_SLOTS),
        .HOLD_SLOTS  (HOLD_SLOTS),
        .TABLE_SLOTS (TABLE_SLOTS),
        .PROBE_RUN   (PROBE_RUN),
        .SEQ_WIDTH   (SEQ_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_op),
        .i_key_hash    (i_key_hash),
        .i_seq_a       (i_seq_a),
        .i_seq_b       (i_seq_b),
        .i_floor_seq   (i_floor_seq),
        .i_commit_flag (i_commit_flag),
        .i_packed_in   (i_packed_in),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_flag        (o_flag)
    );

endmodule
